// ===== hw/rtl/sbig_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbig_pkg
// Shared field widths, input modes, result codes and the command type that
// travels from the front end to the back end of the batch index generator.
// ----------------------------------------------------------------------------
package sbig_pkg;

  localparam int MODE_W    = 2;
  localparam int RAND_W    = 31;
  localparam int ROW_IDX_W = 10;
  localparam int STATUS_W  = 3;
  localparam int ROWCNT_W  = 11;
  localparam int BATCH_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = ROWCNT_W;

  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FETCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INDEX      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_DATA    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RESET_DONE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SWAP_DONE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PASS_DONE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIM = 1'b1;

  localparam logic [ROWCNT_W-1:0] ROWCNT_RST = 11'd1024;
  localparam logic [BATCH_W-1:0]  BATCH_RST  = 7'd32;

  typedef enum logic [1:0] {
    OP_RESET,
    OP_SWAP,
    OP_FETCH
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [RAND_W-1:0] rnd;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sbig_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbig_if
// Valid/ready channels of the batch index generator: request and result.
// ----------------------------------------------------------------------------
interface sbig_in_if;
  import sbig_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [RAND_W-1:0] random_value;
  modport source (output valid, output mode, output random_value, input ready);
  modport sink   (input valid, input mode, input random_value, output ready);
endinterface

interface sbig_out_if;
  import sbig_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROW_IDX_W-1:0] row_index;
  logic                 last_of_run;
  logic [STATUS_W-1:0]  status;
  modport source (output valid, output row_index, output last_of_run, output status,
                  input ready);
  modport sink   (input valid, input row_index, input last_of_run, input status,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/shuffled_batch_index_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_batch_index_generator
// Permutation table of row indices with in-place shuffle steps and batched
// index readout.
//
//   port     dir   beat contents
//   in_ch    sink  mode, random_value
//   out_ch   src   row_index, last_of_run, status
//   cfg_*    in    row_count (index 0), batch limit (index 1)
//
// Reset or mode 0: identity fill of MAX_ROWS entries, one entry per cycle,
//   the table takes no command meanwhile (mode 0 then reports).
// Shuffle step: the 31-step remainder unit picks the swap partner, then one swap.
// Batch fetch: each index is read (S_FRD), then registered out (S_FOUT), one at a time.
// Requests queue two deep ahead of the table; either side may stall.
// ----------------------------------------------------------------------------
module shuffled_batch_index_generator #(
  parameter int MAX_ROWS  = 1024,
  parameter int MAX_BATCH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  sbig_in_if.sink                             in_ch,
  sbig_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [sbig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sbig_pkg::CFG_W-1:0]     cfg_wdata
);
  import sbig_pkg::*;

  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int NW = (CW > ROWCNT_W) ? CW : ROWCNT_W;

  logic [ROWCNT_W-1:0] row_count_r;
  logic [BATCH_W-1:0]  batch_lim_r;
  logic [CW-1:0]       n_eff;
  logic [BATCH_W-1:0]  batch_eff;

  cmd_t  f_cmd;
  logic  f_valid;
  logic  f_ready;
  cmd_t  q_cmd;
  logic  q_valid;
  logic  q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWCNT_RST;
      batch_lim_r <= BATCH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_COUNT: row_count_r <= cfg_wdata[ROWCNT_W-1:0];
        CFG_BATCH_LIM: batch_lim_r <= cfg_wdata[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_count_r == '0) begin
      n_eff = CW'(1);
    end else if (NW'(row_count_r) > NW'(MAX_ROWS)) begin
      n_eff = CW'(MAX_ROWS);
    end else begin
      n_eff = CW'(row_count_r);
    end
    if (batch_lim_r == '0) begin
      batch_eff = BATCH_W'(1);
    end else if (batch_lim_r > BATCH_W'(MAX_BATCH)) begin
      batch_eff = BATCH_W'(MAX_BATCH);
    end else begin
      batch_eff = batch_lim_r;
    end
  end

  sbig_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  sbig_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  sbig_back #(.MAX_ROWS(MAX_ROWS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .n_eff     (n_eff),
    .batch_eff (batch_eff),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sbig_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbig_front
// Accepts request beats, decodes the mode into a command and holds it until
// the command queue takes it. Mode three is dropped here.
// ----------------------------------------------------------------------------
module sbig_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sbig_in_if.sink            in_ch,
  output sbig_pkg::cmd_t     cmd,
  output logic               cmd_valid,
  input  wire logic          cmd_ready
);
  import sbig_pkg::*;

  logic  hold_r;
  cmd_t  cmd_r;
  cmd_t  dec;
  logic  dec_ok;
  logic  take;

  always_comb begin
    dec.rnd = in_ch.random_value;
    dec.op  = OP_RESET;
    dec_ok  = 1'b1;
    unique case (in_ch.mode)
      MODE_RESET: dec.op = OP_RESET;
      MODE_SWAP:  dec.op = OP_SWAP;
      MODE_FETCH: dec.op = OP_FETCH;
      default:    dec_ok = 1'b0;
    endcase
  end

  assign in_ch.ready = !hold_r || cmd_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = hold_r;
  assign cmd         = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (take) begin
      hold_r <= dec_ok;
    end else if (cmd_ready) begin
      hold_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= dec;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbig_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbig_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module sbig_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sbig_pkg::cmd_t push_cmd,
  input  wire logic           push_valid,
  output logic                push_ready,
  output sbig_pkg::cmd_t      pop_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready
);
  import sbig_pkg::*;

  cmd_t        ent_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbig_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbig_div
// Restoring remainder unit, one dividend bit per cycle. Gives the random
// word modulo the shuffle bound.
// ----------------------------------------------------------------------------
module sbig_div #(
  parameter int DW = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [sbig_pkg::RAND_W-1:0] dividend,
  input  wire logic [DW-1:0]               divisor,
  output logic                             done,
  output logic [DW-1:0]                    rem
);
  import sbig_pkg::*;

  localparam int CNT_W = $clog2(RAND_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(RAND_W - 1);

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAND_W-1:0] quo_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dvs_r;
  logic [DW:0]       trial;
  logic [DW-1:0]     rem_nxt;

  always_comb begin
    trial = {rem_r, quo_r[RAND_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DW'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = DW'(trial);
    end
  end

  assign done = busy_r && (cnt_r == LAST);
  assign rem  = rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (done) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_r << 1;
      rem_r <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sbig_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbig_back
// Executes commands against the order table: identity fill, one swap per
// shuffle step (a step at position zero only ends the pass), and batch reads. Results leave through an output register.
// ----------------------------------------------------------------------------
module sbig_back #(
  parameter int MAX_ROWS = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sbig_pkg::cmd_t                      cmd,
  input  wire logic                                cmd_valid,
  output logic                                     cmd_ready,
  input  wire logic [$clog2(MAX_ROWS+1)-1:0]       n_eff,
  input  wire logic [sbig_pkg::BATCH_W-1:0]        batch_eff,
  sbig_out_if.source                               out_ch
);
  import sbig_pkg::*;

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int TW = (CW > BATCH_W) ? CW : BATCH_W;
  localparam int XW = (AW > ROW_IDX_W) ? AW : ROW_IDX_W;
  localparam int RST_ROWS = (MAX_ROWS < 1024) ? MAX_ROWS : 1024;
  localparam logic [AW-1:0] SHUF_RST = AW'(RST_ROWS - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ROWS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SWRD, S_SWA, S_SWB, S_FRD, S_FOUT
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        mem [MAX_ROWS];
  logic [AW-1:0]        rd_a_r;
  logic [AW-1:0]        rd_b_r;
  logic [AW-1:0]        tmp_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 clr_report_r;
  logic [CW-1:0]        read_pos_r;
  logic [AW-1:0]        shuf_r;
  logic [AW-1:0]        p_r;
  logic [AW-1:0]        j_r;
  logic [BATCH_W-1:0]   take_r;
  logic                 out_valid_r;
  logic [ROW_IDX_W-1:0] out_row_r;
  logic                 out_last_r;
  logic [STATUS_W-1:0]  out_status_r;

  logic                 slot_free;
  logic [CW-1:0]        n_m1;
  logic [AW-1:0]        p_eff;
  logic [AW-1:0]        p_dec;
  logic [CW-1:0]        remain;
  logic [BATCH_W-1:0]   take;
  logic                 exhausted;
  logic                 div_start;
  logic                 div_done;
  logic [CW-1:0]        div_rem;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_wdata;
  logic [AW-1:0]        addr_a;
  logic [XW-1:0]        idx_ext;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign cmd_ready = (state_r == S_IDLE) && slot_free;
  assign n_m1      = n_eff - CW'(1);
  assign p_eff     = (CW'(shuf_r) > n_m1) ? AW'(n_m1) : shuf_r;
  assign p_dec     = p_r - AW'(1);
  assign exhausted = (read_pos_r >= n_eff);
  assign remain    = n_eff - read_pos_r;
  assign take      = (TW'(remain) > TW'(batch_eff)) ? batch_eff : BATCH_W'(remain);
  assign div_start = cmd_valid && cmd_ready && (cmd.op == OP_SWAP) && (p_eff != '0);
  assign idx_ext   = XW'(rd_a_r);

  sbig_div #(.DW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cmd.rnd),
    .divisor  (CW'(p_eff) + CW'(1)),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = clr_cnt_r;
    addr_a    = AW'(read_pos_r);
    unique case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_SWRD:  addr_a = p_r;
      S_SWA: begin
        mem_we    = 1'b1;
        mem_waddr = p_r;
        mem_wdata = rd_b_r;
      end
      S_SWB: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = tmp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      clr_report_r <= 1'b0;
      read_pos_r   <= '0;
      shuf_r       <= SHUF_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          if (clr_cnt_r != CLR_LAST) begin
            clr_cnt_r <= clr_cnt_r + AW'(1);
          end else if (!clr_report_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_row_r    <= '0;
            out_last_r   <= 1'b1;
            out_status_r <= ST_RESET_DONE;
            clr_report_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid && slot_free) begin
            unique case (cmd.op)
              OP_RESET: begin
                read_pos_r   <= '0;
                shuf_r       <= AW'(n_m1);
                clr_cnt_r    <= '0;
                clr_report_r <= 1'b1;
                state_r      <= S_CLEAR;
              end
              OP_SWAP: begin
                if (p_eff == '0) begin
                  shuf_r       <= AW'(n_m1);
                  read_pos_r   <= '0;
                  out_valid_r  <= 1'b1;
                  out_row_r    <= '0;
                  out_last_r   <= 1'b1;
                  out_status_r <= ST_PASS_DONE;
                end else begin
                  p_r     <= p_eff;
                  state_r <= S_DIV;
                end
              end
              OP_FETCH: begin
                if (exhausted) begin
                  out_valid_r  <= 1'b1;
                  out_row_r    <= '0;
                  out_last_r   <= 1'b1;
                  out_status_r <= ST_NO_DATA;
                end else begin
                  take_r  <= take;
                  state_r <= S_FRD;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            j_r     <= AW'(div_rem);
            state_r <= S_SWRD;
          end
        end
        S_SWRD: state_r <= S_SWA;
        S_SWA: begin
          tmp_r   <= rd_a_r;
          state_r <= S_SWB;
        end
        S_SWB: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_row_r   <= '0;
            out_last_r  <= 1'b1;
            if (p_dec == '0) begin
              shuf_r       <= AW'(n_m1);
              read_pos_r   <= '0;
              out_status_r <= ST_PASS_DONE;
            end else begin
              shuf_r       <= p_dec;
              out_status_r <= ST_SWAP_DONE;
            end
            state_r <= S_IDLE;
          end
        end
        S_FRD: state_r <= S_FOUT;
        S_FOUT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_row_r    <= idx_ext[ROW_IDX_W-1:0];
            out_last_r   <= (take_r == BATCH_W'(1));
            out_status_r <= ST_INDEX;
            read_pos_r   <= read_pos_r + CW'(1);
            take_r       <= take_r - BATCH_W'(1);
            state_r      <= (take_r == BATCH_W'(1)) ? S_IDLE : S_FRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_index   = out_row_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.status      = out_status_r;

endmodule
`default_nettype wire
